FILE: rtl/core/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and helpers for the Modbus RTU request framer
// Request kinds, function codes, CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

  typedef enum logic [1:0] {
    KIND_READ         = 2'd0,
    KIND_WRITE_SINGLE = 2'd1,
    KIND_WRITE_MULTI  = 2'd2,
    KIND_DATA         = 2'd3
  } kind_t;

  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  // byte position within one request's output, 0..8
  localparam int IDX_W = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } beat_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mrf_frame_seq.sv
// ----------------------------------------------------------------------------
// mrf_frame_seq: request register and byte sequencer
// Holds one request, emits its bytes one per cycle while out_room allows, keeps the running CRC
// and the count of data words still owed to an open write-multiple frame.
// ----------------------------------------------------------------------------
module mrf_frame_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrf_pkg::item_t in_item,
  input  logic           out_room,
  output logic           beat_valid,
  output mrf_pkg::beat_t beat
);
  import mrf_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [15:0]      words_remaining;
  kind_t            cur_kind;
  logic [7:0]       cur_slave;
  logic [15:0]      cur_addr;
  logic [15:0]      cur_word;
  logic             cur_close;

  logic [IDX_W-1:0] crc_start;
  logic [IDX_W-1:0] end_idx;
  logic [7:0]       fc;
  logic [7:0]       data_byte;
  logic [7:0]       out_byte;
  logic             is_crc;
  logic             is_crc_hi;
  logic             last;
  logic             advance;
  logic             accept;
  logic             stray;
  logic             load;
  logic             close_in;
  logic [15:0]      crc_in;
  logic [15:0]      crc_next;
  logic [15:0]      words_remaining_next;

  always_comb begin
    unique case (cur_kind)
      KIND_READ:         fc = FC_READ;
      KIND_WRITE_SINGLE: fc = FC_WRITE_SINGLE;
      default:           fc = FC_WRITE_MULTI;
    endcase

    unique case (cur_kind)
      KIND_DATA:        crc_start = IDX_W'(2);
      KIND_WRITE_MULTI: crc_start = IDX_W'(7);
      default:          crc_start = IDX_W'(6);
    endcase
    // frame without a CRC tail ends on the byte before crc_start
    end_idx = cur_close ? (crc_start + IDX_W'(1)) : (crc_start - IDX_W'(1));

    if (cur_kind == KIND_DATA) begin
      data_byte = idx[0] ? cur_word[7:0] : cur_word[15:8];
    end else begin
      case (idx)
        IDX_W'(0): data_byte = cur_slave;
        IDX_W'(1): data_byte = fc;
        IDX_W'(2): data_byte = cur_addr[15:8];
        IDX_W'(3): data_byte = cur_addr[7:0];
        IDX_W'(4): data_byte = cur_word[15:8];
        IDX_W'(5): data_byte = cur_word[7:0];
        default:   data_byte = {cur_word[6:0], 1'b0};  // byte count, wraps
      endcase
    end

    is_crc    = cur_close && (idx >= crc_start);
    is_crc_hi = is_crc && (idx != crc_start);
    out_byte  = is_crc ? (is_crc_hi ? crc[15:8] : crc[7:0]) : data_byte;

    // a header always starts from a fresh CRC, abandoning any open frame
    crc_in   = ((cur_kind != KIND_DATA) && (idx == '0)) ? CRC_INIT : crc;
    crc_next = crc;
    if (is_crc_hi) begin
      crc_next = CRC_INIT;
    end else if (!is_crc) begin
      crc_next = crc16_byte(crc_in, data_byte);
    end

    last     = (idx == end_idx);
    advance  = busy && out_room;
    in_ready = !busy || (advance && last);
    accept   = in_valid && in_ready;
    stray    = (in_item.kind == KIND_DATA) && (words_remaining == '0);
    load     = accept && !stray;

    unique case (in_item.kind)
      KIND_WRITE_MULTI: close_in = (in_item.quantity == '0);
      KIND_DATA:        close_in = (words_remaining == 16'd1);
      default:          close_in = 1'b1;
    endcase

    words_remaining_next = words_remaining;
    if (accept) begin
      if (in_item.kind == KIND_WRITE_MULTI) begin
        words_remaining_next = in_item.quantity;
      end else if (in_item.kind != KIND_DATA) begin
        words_remaining_next = '0;
      end else if (!stray) begin
        words_remaining_next = words_remaining - 16'd1;
      end
    end

    beat_valid      = busy;
    beat.frame_byte = out_byte;
    beat.frame_end  = is_crc_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      idx             <= '0;
      crc             <= CRC_INIT;
      words_remaining <= '0;
    end else begin
      words_remaining <= words_remaining_next;
      if (advance) begin
        crc <= crc_next;
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance && last) begin
        busy <= 1'b0;
      end else if (advance) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_kind  <= in_item.kind;
      cur_slave <= in_item.slave_id;
      cur_addr  <= in_item.start_address;
      cur_word  <= (in_item.kind == KIND_READ || in_item.kind == KIND_WRITE_MULTI) ?
                   in_item.quantity : in_item.value;
      cur_close <= close_in;
    end
  end

endmodule

FILE: rtl/core/modbus_rtu_request_framer_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit: Modbus RTU request framer
// Turns request headers and data words into a CRC-closed byte stream.
// ----------------------------------------------------------------------------
// Each request on the slave side becomes a run of bytes on the master side,
// one byte per cycle unless m_tready stalls the output: read and
// write-single requests give 8 bytes, a write-multiple header gives 7 (9
// when its quantity is zero), and each data word gives 2, plus the two CRC
// bytes (low first, tlast on the high one) after the last owed word. A data
// word with no open write-multiple frame is dropped; a new header abandons
// an open frame. The next request is taken in the cycle its predecessor's
// last byte enters the output register, so the stream runs without gaps
// while requests keep arriving, apart from dropped data words.
module modbus_rtu_request_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // slave_id[7:0], start_address[23:8],
                                 // quantity[39:24], value[55:40]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte[7:0]
  output logic        m_tlast
);
  import mrf_pkg::*;

  item_t item;
  beat_t beat;
  logic  beat_valid;
  logic  out_room;

  assign item.kind          = kind_t'(s_tuser);
  assign item.slave_id      = s_tdata[7:0];
  assign item.start_address = s_tdata[23:8];
  assign item.quantity      = s_tdata[39:24];
  assign item.value         = s_tdata[55:40];

  assign out_room = !m_tvalid || m_tready;

  mrf_frame_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .out_room   (out_room),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_room) begin
      m_tvalid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room) begin
      m_tdata <= beat.frame_byte;
      m_tlast <= beat.frame_end;
    end
  end

endmodule
